>>> hw/rtl/assert_macros.svh
// Assertion macros used by the equalizer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define STBEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STBEQ_NEVER(lbl, cond, msg) \
  `STBEQ_ASSERT(lbl, !(cond), msg)
`else
`define STBEQ_ASSERT(lbl, prop, msg)
`define STBEQ_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/stbeq_pkg.sv
// Types, constants and step codes for the stereo three-band equalizer.
package stbeq_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 20;
  localparam int COEF_FRAC    = 16;
  localparam int STATE_WIDTH  = 40;

  localparam int NUM_STAGES  = 3;
  localparam int NUM_DELAYS  = 2 * NUM_STAGES;
  localparam int STAGE_W     = 2;
  localparam int STEP_W      = 3;
  localparam int CFG_INDEX_W = 3;

  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_FF  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_FB  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MID_FF  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MID_FB  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_FF = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_FB = 3'd5;

  localparam logic [STEP_W-1:0] STEP_B0  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_Y   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A1  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_SUB = 3'd3;
  localparam logic [STEP_W-1:0] STEP_D1  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_D2  = 3'd5;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_item_t;

  typedef struct packed {
    logic                load_in;
    logic                run;
    logic [STEP_W-1:0]   step;
    logic [STAGE_W-1:0]  stage;
    logic                ch;
    logic                load_out;
  } cmd_t;

endpackage

>>> hw/rtl/stbeq_ctrl.sv
// Sequencer that steps the shared multiplier through every stage and channel.
`include "assert_macros.svh"

module stbeq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output stbeq_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [stbeq_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [stbeq_pkg::STAGE_W-1:0] stage_r, stage_nxt;
  logic                         ch_r, ch_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;
  logic                         last_step;
  logic                         load_out;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (step_r == stbeq_pkg::STEP_D2) && (stage_r == stbeq_pkg::LAST_STAGE)
                     && ch_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    stage_nxt = stage_r;
    ch_nxt    = ch_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          step_nxt  = stbeq_pkg::STEP_B0;
          stage_nxt = '0;
          ch_nxt    = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_r == stbeq_pkg::STEP_D2) begin
          step_nxt = stbeq_pkg::STEP_B0;
          if (stage_r == stbeq_pkg::LAST_STAGE) begin
            stage_nxt = '0;
            ch_nxt    = ~ch_r;
          end else begin
            stage_nxt = stage_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
        if (last_step) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= stbeq_pkg::STEP_B0;
      stage_r     <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      stage_r     <= stage_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load_in  = in_valid && (state_r == ST_IDLE);
  assign cmd.run      = (state_r == ST_RUN);
  assign cmd.step     = step_r;
  assign cmd.stage    = stage_r;
  assign cmd.ch       = ch_r;
  assign cmd.load_out = load_out;

  `STBEQ_NEVER(a_load_over_held, load_out && out_valid_r && out_stall, "result overwritten")
  `STBEQ_ASSERT(a_start_seq, cmd.load_in |=> (state_r == ST_RUN && step_r == stbeq_pkg::STEP_B0 && stage_r == '0 && !ch_r), "sequence did not start at the first step")
  `STBEQ_ASSERT(a_hold_full, (state_r == ST_HOLD) |-> out_valid_r, "holding with an empty output")
  `STBEQ_NEVER(a_counters_range, step_r > stbeq_pkg::STEP_D2 || stage_r > stbeq_pkg::LAST_STAGE, "step or stage counter out of range")

endmodule

>>> hw/rtl/stbeq_dp.sv
// Datapath: coefficient store, delay states, shared multiplier, rounding and saturation.
module stbeq_dp #(
  parameter int COEF_WIDTH  = stbeq_pkg::COEF_WIDTH,
  parameter int COEF_FRAC   = stbeq_pkg::COEF_FRAC,
  parameter int STATE_WIDTH = stbeq_pkg::STATE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stbeq_pkg::cmd_t                    cmd,
  input  stbeq_pkg::in_item_t                in_data,
  output stbeq_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [stbeq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [3*COEF_WIDTH-1:0]            cfg_data
);

  localparam int SW     = stbeq_pkg::SAMPLE_WIDTH;
  localparam int FF_W   = 3 * COEF_WIDTH;
  localparam int FB_W   = 2 * COEF_WIDTH;
  localparam int PROD_W = COEF_WIDTH + SW;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W + 1 - COEF_FRAC;
  localparam int SUM_W  = ((RND_W > STATE_WIDTH) ? RND_W : STATE_WIDTH) + 1;
  localparam int EXT_W  = SUM_W + COEF_FRAC;
  localparam int NS     = stbeq_pkg::NUM_STAGES;
  localparam int ND     = stbeq_pkg::NUM_DELAYS;
  localparam int DIDX_W = $clog2(ND);

  localparam logic [FF_W-1:0]  FF_RESET = FF_W'(1) << COEF_FRAC;
  localparam logic [EXT_W-1:0] HALF     = EXT_W'(1) << (COEF_FRAC - 1);

  logic [FF_W-1:0]               ff_r [NS];
  logic [FB_W-1:0]               fb_r [NS];
  logic signed [STATE_WIDTH-1:0] d1_r [ND];
  logic signed [STATE_WIDTH-1:0] d2_r [ND];

  stbeq_pkg::in_item_t           in_r;
  stbeq_pkg::out_item_t          out_r;
  stbeq_pkg::sample_t            x_r;
  stbeq_pkg::sample_t            y_r;
  stbeq_pkg::sample_t            left_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  logic [FF_W-1:0]               ff_sel;
  logic [FB_W-1:0]               fb_sel;
  logic [DIDX_W-1:0]             didx;
  logic signed [COEF_WIDTH-1:0]  coef_sel;
  logic signed [SW-1:0]          opnd_sel;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       diff;
  logic signed [ACC_W-1:0]       rnd_in;
  logic signed [EXT_W-1:0]       rnd_ext;
  logic signed [EXT_W-1:0]       rnd_add;
  logic signed [EXT_W-1:0]       rnd_shift;
  logic signed [SUM_W-1:0]       addend;
  logic signed [SUM_W-1:0]       sum;
  logic                          sum_sign;
  logic                          ovf_smp;
  logic                          ovf_st;
  logic signed [SW-1:0]          y_sat;
  logic signed [STATE_WIDTH-1:0] st_sat;

  assign ff_sel = ff_r[cmd.stage];
  assign fb_sel = fb_r[cmd.stage];
  assign didx   = DIDX_W'({cmd.stage, cmd.ch});

  always_comb begin
    case (cmd.step)
      stbeq_pkg::STEP_B0:  coef_sel = ff_sel[COEF_WIDTH-1:0];
      stbeq_pkg::STEP_Y:   coef_sel = ff_sel[2*COEF_WIDTH-1:COEF_WIDTH];
      stbeq_pkg::STEP_A1:  coef_sel = fb_sel[COEF_WIDTH-1:0];
      stbeq_pkg::STEP_SUB: coef_sel = ff_sel[3*COEF_WIDTH-1:2*COEF_WIDTH];
      stbeq_pkg::STEP_D1:  coef_sel = fb_sel[2*COEF_WIDTH-1:COEF_WIDTH];
      default:             coef_sel = ff_sel[COEF_WIDTH-1:0];
    endcase
  end

  assign opnd_sel = ((cmd.step == stbeq_pkg::STEP_A1) || (cmd.step == stbeq_pkg::STEP_D1))
                    ? y_r : x_r;
  assign prod_nxt = coef_sel * opnd_sel;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};
  assign diff     = acc_r - prod_ext;

  always_comb begin
    case (cmd.step)
      stbeq_pkg::STEP_Y: begin
        rnd_in = prod_ext;
        addend = {{(SUM_W-STATE_WIDTH){d1_r[didx][STATE_WIDTH-1]}}, d1_r[didx]};
      end
      stbeq_pkg::STEP_D1: begin
        rnd_in = acc_r;
        addend = {{(SUM_W-STATE_WIDTH){d2_r[didx][STATE_WIDTH-1]}}, d2_r[didx]};
      end
      default: begin
        rnd_in = diff;
        addend = '0;
      end
    endcase
  end

  assign rnd_ext   = {{(EXT_W-ACC_W){rnd_in[ACC_W-1]}}, rnd_in};
  assign rnd_add   = rnd_ext + $signed(HALF);
  assign rnd_shift = rnd_add >>> COEF_FRAC;
  assign sum       = rnd_shift[SUM_W-1:0] + addend;
  assign sum_sign  = sum[SUM_W-1];

  assign ovf_smp = (sum[SUM_W-1:SW-1] != {(SUM_W-SW+1){sum_sign}});
  assign y_sat   = ovf_smp ? {sum_sign, {(SW-1){~sum_sign}}} : sum[SW-1:0];
  assign ovf_st  = (sum[SUM_W-1:STATE_WIDTH-1] != {(SUM_W-STATE_WIDTH+1){sum_sign}});
  assign st_sat  = ovf_st ? {sum_sign, {(STATE_WIDTH-1){~sum_sign}}} : sum[STATE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        ff_r[i] <= FF_RESET;
        fb_r[i] <= '0;
      end
      for (int i = 0; i < ND; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stbeq_pkg::CFG_LOW_FF:  ff_r[0] <= cfg_data;
          stbeq_pkg::CFG_LOW_FB:  fb_r[0] <= cfg_data[FB_W-1:0];
          stbeq_pkg::CFG_MID_FF:  ff_r[1] <= cfg_data;
          stbeq_pkg::CFG_MID_FB:  fb_r[1] <= cfg_data[FB_W-1:0];
          stbeq_pkg::CFG_HIGH_FF: ff_r[2] <= cfg_data;
          stbeq_pkg::CFG_HIGH_FB: fb_r[2] <= cfg_data[FB_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.run && (cmd.step == stbeq_pkg::STEP_D1)) begin
        d1_r[didx] <= st_sat;
      end
      if (cmd.run && (cmd.step == stbeq_pkg::STEP_D2)) begin
        d2_r[didx] <= st_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
      x_r  <= in_data.left_sample;
    end
    if (cmd.run) begin
      prod_r <= prod_nxt;
      case (cmd.step)
        stbeq_pkg::STEP_Y: begin
          y_r <= y_sat;
        end
        stbeq_pkg::STEP_A1: begin
          acc_r <= prod_ext;
        end
        stbeq_pkg::STEP_SUB: begin
          acc_r <= diff;
        end
        stbeq_pkg::STEP_D1: begin
          acc_r <= prod_ext;
        end
        stbeq_pkg::STEP_D2: begin
          if (cmd.stage == stbeq_pkg::LAST_STAGE) begin
            if (!cmd.ch) begin
              left_r <= y_r;
              x_r    <= in_r.right_sample;
            end
          end else begin
            x_r <= y_r;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_out) begin
      out_r.left_out  <= left_r;
      out_r.right_out <= y_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/stereo_three_band_biquad_eq_top.sv
// Top level of the stereo three-band biquad equalizer.

// Each item is one stereo frame that runs through a low shelf, a peaking and a
// high shelf biquad per channel, left first, then right. One 20 by 24 bit
// multiplier serves all six biquad evaluations in turn, and a new frame is
// taken only after the one before has been fully worked through and its
// result loaded. The next frame is accepted while the previous result still
// waits in the output register. Coefficient writes are taken at any time,
// with ready always high, and must only be made while the block is idle.
module stereo_three_band_biquad_eq_top #(
  parameter int COEF_WIDTH  = stbeq_pkg::COEF_WIDTH,
  parameter int COEF_FRAC   = stbeq_pkg::COEF_FRAC,
  parameter int STATE_WIDTH = stbeq_pkg::STATE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  stbeq_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output stbeq_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [stbeq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [3*COEF_WIDTH-1:0]            cfg_data
);

  stbeq_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  stbeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  stbeq_dp #(
    .COEF_WIDTH  (COEF_WIDTH),
    .COEF_FRAC   (COEF_FRAC),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> dv/stereo_three_band_biquad_eq_top_test.sv
// Self-checking testbench for the stereo three-band biquad equalizer.
`timescale 1ns / 1ps

module stereo_three_band_biquad_eq_top_test;
  import stbeq_pkg::*;

  localparam int NUM_REGS = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEGMENT_FRAMES = 125;
  localparam int UNITY_COEF = 1 << COEF_FRAC;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum {COEF_UNITY, COEF_MILD, COEF_RANDOM, COEF_MAX, COEF_MIN} coef_kind_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [3*COEF_WIDTH-1:0] cfg_data = '0;

  in_item_t pending_frames[$];
  out_item_t expected_frames[$];

  logic [3*COEF_WIDTH-1:0] band_coef[NUM_REGS];
  longint signed band_d1[NUM_DELAYS];
  longint signed band_d2[NUM_DELAYS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_fail = 0;
  int n_frames = 0;
  int n_results = 0;
  int n_programs = 0;

  stereo_three_band_biquad_eq_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint signed clamp(longint signed v, int w);
    longint signed hi;
    longint signed lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint signed round_q(longint signed acc);
    return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint signed coef_of(logic [3*COEF_WIDTH-1:0] r, int k);
    logic signed [COEF_WIDTH-1:0] c;
    c = r[k*COEF_WIDTH +: COEF_WIDTH];
    return c;
  endfunction

  function automatic longint signed biquad(int stage, int ch, longint signed x);
    longint signed b0, b1, b2, a1, a2, y, n1, n2;
    int idx;
    b0 = coef_of(band_coef[2*stage], 0);
    b1 = coef_of(band_coef[2*stage], 1);
    b2 = coef_of(band_coef[2*stage], 2);
    a1 = coef_of(band_coef[2*stage+1], 0);
    a2 = coef_of(band_coef[2*stage+1], 1);
    idx = 2*stage + ch;
    y = clamp(round_q(b0*x) + band_d1[idx], SAMPLE_WIDTH);
    n1 = clamp(round_q(b1*x - a1*y) + band_d2[idx], STATE_WIDTH);
    n2 = clamp(round_q(b2*x - a2*y), STATE_WIDTH);
    band_d1[idx] = n1;
    band_d2[idx] = n2;
    return y;
  endfunction

  function automatic out_item_t equalize_frame(in_item_t f);
    longint signed v;
    out_item_t r;
    v = f.left_sample;
    for (int s = 0; s < NUM_STAGES; s++) v = biquad(s, 0, v);
    r.left_out = v[SAMPLE_WIDTH-1:0];
    v = f.right_sample;
    for (int s = 0; s < NUM_STAGES; s++) v = biquad(s, 1, v);
    r.right_out = v[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [COEF_WIDTH-1:0] pick_coef(coef_kind_t kind, int unity, int span);
    case (kind)
      COEF_UNITY:  return COEF_WIDTH'(unity);
      COEF_MILD:   return COEF_WIDTH'(unity + int'($urandom_range(2*span)) - span);
      COEF_RANDOM: return COEF_WIDTH'($urandom);
      COEF_MAX:    return {1'b0, {(COEF_WIDTH-1){1'b1}}};
      default:     return {1'b1, {(COEF_WIDTH-1){1'b0}}};
    endcase
  endfunction

  function automatic logic [3*COEF_WIDTH-1:0] make_ff(coef_kind_t kind);
    return {pick_coef(kind, 0, 65536), pick_coef(kind, 0, 65536),
            pick_coef(kind, UNITY_COEF, 32768)};
  endfunction

  // Poles stay inside the unit circle for the mild setting.
  function automatic logic [3*COEF_WIDTH-1:0] make_fb(coef_kind_t kind);
    return {COEF_WIDTH'($urandom), pick_coef(kind, 0, 32768), pick_coef(kind, 0, 29491)};
  endfunction

  function automatic sample_t rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return sample_t'(-1);
        default: return sample_t'(0);
      endcase
    end
    if (pick < 60) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(131072)) - 65536);
  endfunction

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [3*COEF_WIDTH-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= CFG_HIGH_FB) begin
      if (idx[0]) band_coef[idx] = {{COEF_WIDTH{1'b0}}, val[2*COEF_WIDTH-1:0]};
      else band_coef[idx] = val;
    end
  endtask

  task automatic program_bands(coef_kind_t kind);
    cfg_write(CFG_LOW_FF, make_ff(kind));
    cfg_write(CFG_LOW_FB, make_fb(kind));
    cfg_write(CFG_MID_FF, make_ff(kind));
    cfg_write(CFG_MID_FB, make_fb(kind));
    cfg_write(CFG_HIGH_FF, make_ff(kind));
    cfg_write(CFG_HIGH_FB, make_fb(kind));
    cfg_write(n_programs[0] ? CFG_SPARE_HI : CFG_SPARE_LO,
              (3*COEF_WIDTH)'({$urandom, $urandom}));
    n_programs++;
  endtask

  task automatic push_pair(sample_t l, sample_t r);
    in_item_t f;
    f.left_sample = l;
    f.right_sample = r;
    pending_frames.push_back(f);
  endtask

  task automatic push_random(int n);
    repeat (n) push_pair(rand_sample(), rand_sample());
  endtask

  task automatic push_extremes();
    push_pair(SAMPLE_MAX, SAMPLE_MIN);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(SAMPLE_MIN, SAMPLE_MIN);
    push_pair(sample_t'(1), sample_t'(-1));
    push_pair(sample_t'(0), sample_t'(0));
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(SAMPLE_MAX, sample_t'(0));
    push_pair(sample_t'(0), SAMPLE_MIN);
  endtask

  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_frames.push_back(equalize_frame(in_data));
        n_frames++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_frames.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_frames.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d",
                 out_data.left_out, out_data.right_out);
          n_fail++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $error("left_out mismatch: expected %0d, got %0d",
                   want.left_out, out_data.left_out);
            n_fail++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out mismatch: expected %0d, got %0d",
                   want.right_out, out_data.right_out);
            n_fail++;
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    coef_kind_t kind;
    bit pressure;
    for (int i = 0; i < NUM_REGS; i++) begin
      band_coef[i] = i[0] ? '0 : (3*COEF_WIDTH)'(UNITY_COEF);
      band_d1[i] = 0;
      band_d2[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_pair(sample_t'(0), sample_t'(0));
    push_pair(SAMPLE_MAX, SAMPLE_MIN);
    push_pair(SAMPLE_MIN, SAMPLE_MAX);
    push_pair(sample_t'(-1), sample_t'(1));
    push_pair(sample_t'(1), sample_t'(-1));
    push_pair(24'sh555555, 24'shAAAAAA);
    wait_idle();
    program_bands(COEF_MAX);
    push_extremes();
    wait_idle();
    program_bands(COEF_MIN);
    push_extremes();
    wait_idle();

    for (int seg = 0; seg < 8; seg++) begin
      pressure = 1'b0;
      case (seg)
        0: begin kind = COEF_MILD;   send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin kind = COEF_RANDOM; send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin kind = COEF_MILD;   send_idle_pct = 0;  recv_stall_pct = 65; end
        3: begin kind = COEF_RANDOM; send_idle_pct = 16; recv_stall_pct = 16; end
        4: begin kind = COEF_MILD;   send_idle_pct = 0;  recv_stall_pct = 0;
                 pressure = 1'b1; end
        5: begin kind = COEF_MAX;    send_idle_pct = 16; recv_stall_pct = 16; end
        6: begin kind = COEF_MILD;   send_idle_pct = 65; recv_stall_pct = 0;  end
        default: begin kind = COEF_MIN; send_idle_pct = 0; recv_stall_pct = 65; end
      endcase
      program_bands(kind);
      if (pressure) begin
        // The output is held off while frames keep coming, so the input backs up.
        hold_reqs++;
        push_random(SEGMENT_FRAMES / 2);
        wait_idle();
        push_random(SEGMENT_FRAMES - SEGMENT_FRAMES / 2);
      end else begin
        push_random(SEGMENT_FRAMES);
      end
      wait_idle();
    end

    repeat (60) @(posedge clk);
    $display("Checked %0d of %0d stereo frames over %0d coefficient programs,",
             n_results, n_frames, n_programs);
    $display("with free flow, sender gaps, output stalls, both, and a long output hold.");
    if (n_fail == 0 && expected_frames.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/stbeq_pkg.sv
hw/rtl/stbeq_ctrl.sv
hw/rtl/stbeq_dp.sv
hw/rtl/stereo_three_band_biquad_eq_top.sv
dv/stereo_three_band_biquad_eq_top_test.sv
